FILE: rtl/core/carfe_pkg.sv
// ----------------------------------------------------------------------------
// carfe_pkg
// shared constants, types and cell arithmetic for the coil array ramp encoder
// ----------------------------------------------------------------------------
package carfe_pkg;

  localparam int ROWS        = 2;
  localparam int COLS        = 6;
  localparam int NCELLS      = ROWS * COLS;
  localparam int NPAIRS      = (NCELLS + 1) / 2;
  localparam int PAIR_W      = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;
  localparam int LEVEL_W     = 8;
  localparam int CODE_W      = 3;
  localparam int IDX_W       = 4;
  localparam int MASK_W      = 12;
  localparam logic [MASK_W-1:0] MASK_RESET = 12'd772;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [PAIR_W-1:0]         pair_idx_t;

  // controller to datapath
  typedef struct packed {
    logic      wr_target;  // store input target
    logic      clr_chg;    // start of tick
    logic      ramp;       // ramp pair at idx
    logic      emit;       // load output byte for pair at idx
    logic      last;       // final pair of the frame
    pair_idx_t idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

  // one ramp step toward the target, done one bit wider so nothing wraps
  function automatic level_t ramp_step(input level_t c, input level_t t);
    logic signed [LEVEL_W:0] cw;
    logic signed [LEVEL_W:0] tw;
    logic signed [LEVEL_W:0] s;
    cw = {c[LEVEL_W-1], c};
    tw = {t[LEVEL_W-1], t};
    s  = cw;
    if (cw < tw) begin
      s = cw + 9'sd2;
      if (s > tw) s = tw;
    end else if (cw > tw) begin
      s = cw - 9'sd1;
      if (s < tw) s = tw;
    end
    return s[LEVEL_W-1:0];
  endfunction

  // offset, clamp to +-3, magnitude plus polarity bit
  function automatic logic [CODE_W-1:0] encode(input level_t lvl, input logic dir);
    logic signed [LEVEL_W:0] t;
    logic signed [LEVEL_W:0] m;
    logic                    neg;
    t = {lvl[LEVEL_W-1], lvl} - 9'sd3;
    if (t > 9'sd3)  t = 9'sd3;
    if (t < -9'sd3) t = -9'sd3;
    neg = t[LEVEL_W];
    m   = neg ? -t : t;
    return {neg ^ dir, m[1:0]};
  endfunction

endpackage

FILE: rtl/core/coil_array_ramp_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// coil_array_ramp_frame_encoder_unit
// coil array target/current level ramp with packed 3-bit frame encoding
// ----------------------------------------------------------------------------
// usage
//   s_axis: one item per write or tick. s_tuser = mode (0 target write,
//   1 frame tick); s_tdata carries cell_index and the signed target level.
//   a target write gives no output item.
//   a tick runs a ramp pass over the cells, two cells a cycle, then an
//   emission pass loads one frame byte a cycle into the output register
//   while the sink keeps up. s_tready stays low from the tick until the
//   emission pass has loaded the last byte, and m_tvalid first rises once
//   the ramp pass is done and the first byte is registered.
//   m_axis: one item per cell pair, even cell code in bits 5:3, odd in 2:0;
//   m_tlast marks the final byte, m_tuser = settled (no level moved).
//   s_tready is high only while the sequencer is idle; the last byte of a
//   frame may still wait in the output register while the next item is taken.
//   a stalled sink holds the emission pass on the current byte, nothing lost.
//   cfg_we writes polarity_mask at once; write it only while idle.
//   reset (rst, synchronous) clears all targets and levels to zero and
//   loads polarity_mask with 772, with no clearing pass.
// ----------------------------------------------------------------------------
module coil_array_ramp_frame_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,      // polarity_mask
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,        // [3:0] cell_index, [11:4] target_level, zero pad
  input  logic        s_tuser,        // mode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,        // [5:0] frame_byte, zero pad
  output logic        m_tlast,        // last_byte
  output logic        m_tuser         // settled
);

  carfe_pkg::cmd_t cmd;
  carfe_pkg::sts_t sts;
  logic [2*carfe_pkg::CODE_W-1:0] frame_byte;

  // sequencer
  carfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .mode     (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // level store, ramp, encode and output register
  carfe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cell_index   (s_tdata[3:0]),
    .target_level (s_tdata[11:4]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (frame_byte),
    .out_last     (m_tlast),
    .out_settled  (m_tuser)
  );

  assign m_tdata = {2'b00, frame_byte};

endmodule

FILE: rtl/core/carfe_ctrl.sv
// ----------------------------------------------------------------------------
// carfe_ctrl
// sequencer: target writes, ramp pass over pairs, then byte emission pass
// ----------------------------------------------------------------------------
module carfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  carfe_pkg::sts_t  sts,
  output carfe_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RAMP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  carfe_pkg::pair_idx_t       cnt;
  carfe_pkg::pair_idx_t       cnt_next;
  logic                       accept;
  logic                       at_last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign at_last  = (cnt == carfe_pkg::PAIR_W'(carfe_pkg::NPAIRS - 1));

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.idx       = cnt;
    cmd.last      = at_last;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == carfe_pkg::MODE_TICK) begin
            cmd.clr_chg = 1'b1;
            cnt_next    = '0;
            state_next  = S_RAMP;
          end else begin
            cmd.wr_target = 1'b1;
          end
        end
      end
      S_RAMP: begin
        cmd.ramp = 1'b1;
        if (at_last) begin
          cnt_next   = '0;
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (at_last) begin
            cnt_next   = '0;
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: rtl/core/carfe_dp.sv
// ----------------------------------------------------------------------------
// carfe_dp
// level storage by cell pair, ramp unit, encoder and output register
// ----------------------------------------------------------------------------
module carfe_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  carfe_pkg::cmd_t                   cmd,
  output carfe_pkg::sts_t                   sts,
  input  logic [carfe_pkg::IDX_W-1:0]       cell_index,
  input  carfe_pkg::level_t                 target_level,
  input  logic                              cfg_we,
  input  logic [carfe_pkg::MASK_W-1:0]      cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2*carfe_pkg::CODE_W-1:0]    out_byte,
  output logic                              out_last,
  output logic                              out_settled
);

  // even and odd cells of a pair live in separate banks
  carfe_pkg::level_t tgt_even [carfe_pkg::NPAIRS];
  carfe_pkg::level_t tgt_odd  [carfe_pkg::NPAIRS];
  carfe_pkg::level_t cur_even [carfe_pkg::NPAIRS];
  carfe_pkg::level_t cur_odd  [carfe_pkg::NPAIRS];

  logic [carfe_pkg::MASK_W-1:0] polarity_mask;
  logic [carfe_pkg::NPAIRS-1:0] dir_even;
  logic [carfe_pkg::NPAIRS-1:0] dir_odd;
  logic                         changed;

  carfe_pkg::pair_idx_t  wr_pair;
  logic                  wr_ok;
  carfe_pkg::level_t     ce;
  carfe_pkg::level_t     co;
  carfe_pkg::level_t     ce_next;
  carfe_pkg::level_t     co_next;
  logic [carfe_pkg::CODE_W-1:0] code_e;
  logic [carfe_pkg::CODE_W-1:0] code_o;
  logic                  odd_present;

  assign wr_pair = carfe_pkg::PAIR_W'(cell_index >> 1);
  assign wr_ok   = (32'(cell_index) < carfe_pkg::NCELLS);

  always_comb begin
    dir_even = '0;
    dir_odd  = '0;
    for (int i = 0; i < carfe_pkg::NCELLS; i++) begin
      if ((i & 1) == 0) dir_even[i >> 1] = polarity_mask[i];
      else              dir_odd[i >> 1]  = polarity_mask[i];
    end
  end

  assign ce      = cur_even[cmd.idx];
  assign co      = cur_odd[cmd.idx];
  assign ce_next = carfe_pkg::ramp_step(ce, tgt_even[cmd.idx]);
  assign co_next = carfe_pkg::ramp_step(co, tgt_odd[cmd.idx]);

  // with an odd cell count the last pair has no odd cell
  assign odd_present = (((32'(cmd.idx) << 1) + 1) < carfe_pkg::NCELLS);
  assign code_e = carfe_pkg::encode(ce, dir_even[cmd.idx]);
  assign code_o = odd_present ? carfe_pkg::encode(co, dir_odd[cmd.idx]) : '0;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < carfe_pkg::NPAIRS; p++) begin
        tgt_even[p] <= '0;
        tgt_odd[p]  <= '0;
        cur_even[p] <= '0;
        cur_odd[p]  <= '0;
      end
      polarity_mask <= carfe_pkg::MASK_RESET;
      changed       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) polarity_mask <= cfg_wdata;
      if (cmd.wr_target && wr_ok) begin
        if (cell_index[0]) tgt_odd[wr_pair]  <= target_level;
        else               tgt_even[wr_pair] <= target_level;
      end
      if (cmd.clr_chg) changed <= 1'b0;
      if (cmd.ramp) begin
        cur_even[cmd.idx] <= ce_next;
        cur_odd[cmd.idx]  <= co_next;
        if ((ce_next != ce) || (co_next != co)) changed <= 1'b1;
      end
      if (cmd.emit)           out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= {code_e, code_o};
      out_last    <= cmd.last;
      out_settled <= !changed;
    end
  end

endmodule
